// ===== sv/hj_pkg.sv =====
package hj_pkg;

  localparam int KEY_SLOTS   = 1024;
  localparam int SLOT_W      = $clog2(KEY_SLOTS);
  localparam int BUILD_ROWS  = 4096;
  localparam int ENTRY_W     = $clog2(BUILD_ROWS);
  localparam int FILL_W      = ENTRY_W + 1;
  localparam int MAX_MATCHES = 64;
  localparam int CNT_W       = 7;
  localparam int ROW_W       = 20;
  localparam int KEY_W       = 32;

  localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E37_79B1;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_BUILD = 2'd0;
  localparam logic [1:0] OP_PROBE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  // Result kinds.
  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_OVF  = 1'b1;

  // Work item handed from the front to the back.
  typedef struct packed {
    logic [1:0]        op;
    logic [KEY_W-1:0]  key;
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] hash;
  } q_item_t;

  // One entry of the key slot table.
  typedef struct packed {
    logic               used;
    logic [KEY_W-1:0]   key;
    logic [ENTRY_W-1:0] head;
    logic [ENTRY_W-1:0] tail;
    logic [CNT_W-1:0]   count;
  } slot_ent_t;

  // Home slot of a key: multiplicative hash, low bits of the product.
  function automatic logic [SLOT_W-1:0] hash_slot(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] prod;
    prod = key * HASH_MULT;
    return prod[SLOT_W-1:0];
  endfunction

endpackage

// ===== sv/hj_in_if.sv =====
interface hj_in_if
  import hj_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic signed [KEY_W-1:0] join_key;
  logic                    key_present;
  logic [ROW_W-1:0]        row_number;

  modport source (output valid, op, join_key, key_present, row_number, input ready);
  modport sink   (input valid, op, join_key, key_present, row_number, output ready);
endinterface

// ===== sv/hj_out_if.sv =====
interface hj_out_if
  import hj_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ROW_W-1:0] left_row;
  logic [ROW_W-1:0] right_row;
  logic             last;

  modport source (output valid, kind, left_row, right_row, last, input ready);
  modport sink   (input valid, kind, left_row, right_row, last, output ready);
endinterface

// ===== sv/hj_front.sv =====
module hj_front
  import hj_pkg::*;
(
  hj_in_if.sink     in_ch,
  input  logic      q_full,
  output logic      push,
  output q_item_t   item
);

  logic keep;

  // Beats that change nothing and give no result are dropped here.
  always_comb begin
    case (in_ch.op)
      OP_CLEAR: keep = 1'b1;
      OP_BUILD: keep = in_ch.key_present;
      OP_PROBE: keep = in_ch.key_present;
      default:  keep = 1'b0;
    endcase
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full && keep;

  // Hash is computed on the way into the queue.
  assign item.op   = in_ch.op;
  assign item.key  = in_ch.join_key;
  assign item.row  = in_ch.row_number;
  assign item.hash = hash_slot(in_ch.join_key);

endmodule

// ===== sv/hj_fifo.sv =====
module hj_fifo
  import hj_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output q_item_t q_item
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  q_item_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]     cnt_r;
  logic               do_pop;

  assign full    = (cnt_r == (PTR_W+1)'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

// ===== sv/hj_back.sv =====
module hj_back
  import hj_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      build_is_left,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      q_pop,
  hj_out_if.source  out_ch
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_OVF  = 4'd4;
  localparam logic [3:0] S_BLD1 = 4'd5;
  localparam logic [3:0] S_BLD2 = 4'd6;
  localparam logic [3:0] S_PRD  = 4'd7;
  localparam logic [3:0] S_PEM  = 4'd8;

  slot_ent_t          slot_mem [KEY_SLOTS];
  logic [ROW_W-1:0]   rows_mem [BUILD_ROWS];
  logic [ENTRY_W-1:0] link_mem [BUILD_ROWS];

  logic [3:0]         state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [SLOT_W-1:0]  h_r, h_nxt;
  logic [SLOT_W-1:0]  n_r, n_nxt;
  logic               found_r, found_nxt;
  logic [ENTRY_W-1:0] head_r, head_nxt;
  logic [ENTRY_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [ENTRY_W-1:0] e_r, e_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [SLOT_W-1:0]  clr_r, clr_nxt;

  slot_ent_t          slot_rd_r;
  logic [ROW_W-1:0]   rows_rd_r;
  logic [ENTRY_W-1:0] link_rd_r;

  logic               slot_we;
  slot_ent_t          slot_wd;
  logic [SLOT_W-1:0]  slot_wa;
  logic               row_we;
  logic               link_we;
  logic [ENTRY_W-1:0] link_wa, link_wd;

  logic               out_valid_r, out_valid_nxt;
  logic               kind_r, kind_nxt;
  logic [ROW_W-1:0]   left_r, left_nxt;
  logic [ROW_W-1:0]   right_r, right_nxt;
  logic               last_r, last_nxt;
  logic               out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  // Synchronous memories with registered reads.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_r <= slot_mem[h_r];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      rows_mem[fill_r[ENTRY_W-1:0]] <= row_r;
    end
    rows_rd_r <= rows_mem[e_r];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_r <= link_mem[e_r];
  end

  // Sequencer: slot search, insert, overflow report, chain walk and clearing sweep.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    row_nxt       = row_r;
    h_nxt         = h_r;
    n_nxt         = n_r;
    found_nxt     = found_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    e_nxt         = e_r;
    fill_nxt      = fill_r;
    clr_nxt       = clr_r;
    q_pop         = 1'b0;
    slot_we       = 1'b0;
    slot_wa       = h_r;
    slot_wd       = '0;
    row_we        = 1'b0;
    link_we       = 1'b0;
    link_wa       = fill_r[ENTRY_W-1:0];
    link_wd       = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    kind_nxt      = kind_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    last_nxt      = last_r;

    case (state_r)
      S_CLR: begin
        slot_we  = 1'b1;
        slot_wa  = clr_r;
        fill_nxt = '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == SLOT_W'(KEY_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          op_nxt  = q_item.op;
          key_nxt = q_item.key;
          row_nxt = q_item.row;
          h_nxt   = q_item.hash;
          n_nxt   = '0;
          clr_nxt = '0;
          if (q_item.op == OP_CLEAR) begin
            state_nxt = S_CLR;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (slot_rd_r.used && slot_rd_r.key != key_r &&
            n_r != SLOT_W'(KEY_SLOTS - 1)) begin
          h_nxt     = h_r + 1'b1;
          n_nxt     = n_r + 1'b1;
          state_nxt = S_RD;
        end else begin
          found_nxt = slot_rd_r.used && slot_rd_r.key == key_r;
          head_nxt  = slot_rd_r.head;
          tail_nxt  = slot_rd_r.tail;
          count_nxt = slot_rd_r.count;
          if (op_r == OP_BUILD) begin
            if (fill_r == FILL_W'(BUILD_ROWS) ||
                (slot_rd_r.used && slot_rd_r.key != key_r) ||
                (slot_rd_r.used && slot_rd_r.count >= CNT_W'(MAX_MATCHES))) begin
              state_nxt = S_OVF;
            end else begin
              state_nxt = S_BLD1;
            end
          end else if (slot_rd_r.used && slot_rd_r.key == key_r) begin
            e_nxt     = slot_rd_r.head;
            i_nxt     = '0;
            state_nxt = S_PRD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OVF: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_OVF;
          left_nxt      = build_is_left ? row_r : '0;
          right_nxt     = build_is_left ? '0 : row_r;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_BLD1: begin
        slot_we      = 1'b1;
        slot_wd.used = 1'b1;
        slot_wd.key  = key_r;
        slot_wd.tail = fill_r[ENTRY_W-1:0];
        if (found_r) begin
          slot_wd.head  = head_r;
          slot_wd.count = count_r + 1'b1;
          state_nxt     = S_BLD2;
        end else begin
          slot_wd.head  = fill_r[ENTRY_W-1:0];
          slot_wd.count = CNT_W'(1);
          state_nxt     = S_IDLE;
        end
        row_we   = 1'b1;
        link_we  = 1'b1;
        e_nxt    = fill_r[ENTRY_W-1:0];
        fill_nxt = fill_r + 1'b1;
      end
      S_BLD2: begin
        link_we   = 1'b1;
        link_wa   = tail_r;
        link_wd   = e_r;
        state_nxt = S_IDLE;
      end
      S_PRD: begin
        state_nxt = S_PEM;
      end
      S_PEM: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_PAIR;
          left_nxt      = build_is_left ? rows_rd_r : row_r;
          right_nxt     = build_is_left ? row_r : rows_rd_r;
          last_nxt      = (i_r + 1'b1 == count_r);
          i_nxt         = i_r + 1'b1;
          e_nxt         = link_rd_r;
          state_nxt     = (i_r + 1'b1 == count_r) ? S_IDLE : S_PRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state; reset starts the clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the current item and the result beat.
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    row_r   <= row_nxt;
    h_r     <= h_nxt;
    n_r     <= n_nxt;
    found_r <= found_nxt;
    head_r  <= head_nxt;
    tail_r  <= tail_nxt;
    count_r <= count_nxt;
    i_r     <= i_nxt;
    e_r     <= e_nxt;
    kind_r  <= kind_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = kind_r;
  assign out_ch.left_row  = left_r;
  assign out_ch.right_row = right_r;
  assign out_ch.last      = last_r;

  // No work is taken while the table is being swept.
  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !q_pop)
    else $error("queue popped during clearing sweep");

  // The row store never fills beyond its size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(BUILD_ROWS))
    else $error("row store fill count out of range");

  // An overflow beat is always the last of its item.
  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_OVF |-> last_r)
    else $error("overflow beat without last");

  // The final match of a chain returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PEM && out_free && (i_r + 1'b1 == count_r) |=> state_r == S_IDLE)
    else $error("chain walk did not end after last match");

endmodule

// ===== sv/int32_hash_join.sv =====
// Channel  Dir  Beat
// in_ch    in   op, join_key, key_present, row_number
// out_ch   out  kind, left_row, right_row, last
// APB      in   one register, build_is_left at byte address 0
//
// A kept input beat enters a four-entry queue; the back end pops an item when idle.
// Slot search reads the slots on the linear probe path in turn; a probe then emits each
// match via S_PRD and S_PEM, a build insert via S_BLD1 and, for a known key, S_BLD2.
// Reset and the clear op sweep all 1024 key slots, one per cycle, taking no item.
// Output stalls hold the back end; the queue keeps taking beats until full.
module int32_hash_join
  import hj_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  hj_in_if.sink       in_ch,
  hj_out_if.source    out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_BUILD_IS_LEFT = 1'b0;

  logic    build_is_left_r;
  logic    push, q_full, q_pop, q_valid;
  q_item_t push_item, q_item;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUILD_IS_LEFT) ? {31'd0, build_is_left_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      build_is_left_r <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_BUILD_IS_LEFT) begin
      build_is_left_r <= pwdata[0];
    end
  end

  hj_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .item   (push_item)
  );

  hj_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  hj_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .build_is_left (build_is_left_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_ch        (out_ch)
  );

endmodule

// ===== bench/testbench.sv =====
module testbench
  import hj_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // One input beat as the stimulus side sees it.
  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic             present;
    logic [ROW_W-1:0] row;
  } join_req_t;

  // One result beat.
  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] left_row;
    logic [ROW_W-1:0] right_row;
    logic             last;
  } join_res_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  hj_in_if  in_ch ();
  hj_out_if out_ch ();

  int32_hash_join u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the join table.
  logic [KEY_W-1:0]   shadow_key   [KEY_SLOTS];
  logic               shadow_used  [KEY_SLOTS];
  logic [ENTRY_W-1:0] shadow_head  [KEY_SLOTS];
  logic [ENTRY_W-1:0] shadow_tail  [KEY_SLOTS];
  int unsigned        shadow_count [KEY_SLOTS];
  logic [ROW_W-1:0]   shadow_rows  [BUILD_ROWS];
  logic [ENTRY_W-1:0] shadow_link  [BUILD_ROWS];
  int unsigned        shadow_fill;
  logic               shadow_build_left;

  join_req_t pending_reqs[$];
  join_res_t expected_pairs[$];
  int        errors;
  int        pairs_seen;
  int        ovf_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Timeout at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

  // Find the slot that holds the key, else the first free slot on its path.
  function automatic int find_key_slot(input logic [KEY_W-1:0] key, output bit hit);
    logic [KEY_W-1:0] prod;
    int h;
    prod = key * 32'd2654435761;
    h = int'(prod % KEY_SLOTS);
    hit = 0;
    for (int n = 0; n < KEY_SLOTS; n++) begin
      if (!shadow_used[h]) return h;
      if (shadow_key[h] == key) begin
        hit = 1;
        return h;
      end
      h = (h + 1) % KEY_SLOTS;
    end
    return KEY_SLOTS;
  endfunction

  // Apply one accepted beat to the shadow table and queue its results.
  task automatic join_predict(input join_req_t r);
    bit hit;
    int s;
    int e;
    join_res_t res;
    if (r.op == OP_CLEAR) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
      shadow_fill = 0;
      return;
    end
    if (r.op == OP_SPARE || !r.present) return;
    s = find_key_slot(r.key, hit);
    if (r.op == OP_BUILD) begin
      if (shadow_fill >= BUILD_ROWS || s >= KEY_SLOTS ||
          (hit && shadow_count[s] >= MAX_MATCHES)) begin
        res.kind = KIND_OVF;
        res.left_row = shadow_build_left ? r.row : '0;
        res.right_row = shadow_build_left ? '0 : r.row;
        res.last = 1'b1;
        expected_pairs = {expected_pairs, res};
        return;
      end
      e = shadow_fill;
      shadow_rows[e] = r.row;
      shadow_link[e] = '0;
      if (hit) begin
        shadow_link[shadow_tail[s]] = ENTRY_W'(e);
        shadow_tail[s] = ENTRY_W'(e);
        shadow_count[s]++;
      end else begin
        shadow_used[s] = 1'b1;
        shadow_key[s] = r.key;
        shadow_head[s] = ENTRY_W'(e);
        shadow_tail[s] = ENTRY_W'(e);
        shadow_count[s] = 1;
      end
      shadow_fill++;
      return;
    end
    if (!hit) return;
    e = shadow_head[s];
    for (int i = 0; i < shadow_count[s]; i++) begin
      res.kind = KIND_PAIR;
      res.left_row = shadow_build_left ? shadow_rows[e] : r.row;
      res.right_row = shadow_build_left ? r.row : shadow_rows[e];
      res.last = (i + 1 == shadow_count[s]);
      expected_pairs = {expected_pairs, res};
      e = shadow_link[e];
    end
  endtask

  // Driver: present queued beats with a random gap before each.
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.op <= OP_BUILD;
      in_ch.join_key <= '0;
      in_ch.key_present <= 1'b0;
      in_ch.row_number <= '0;
      in_gap <= $urandom_range(0, 10);
    end else if (in_ch.valid && !in_ch.ready) begin
      // Hold the beat.
    end else begin
      if (in_ch.valid) join_predict({in_ch.op, in_ch.join_key, in_ch.key_present,
                                     in_ch.row_number});
      if (in_gap > 0 || pending_reqs.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        join_req_t r;
        r = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op <= r.op;
        in_ch.join_key <= r.key;
        in_ch.key_present <= r.present;
        in_ch.row_number <= r.row;
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
    end
  end

  // Monitor: random stalls on the result side, compare every beat.
  int out_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap <= $urandom_range(0, 10);
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        join_res_t got, exp_r;
        got = {out_ch.kind, out_ch.left_row, out_ch.right_row, out_ch.last};
        if (got.kind == KIND_OVF) ovf_seen++; else pairs_seen++;
        if (expected_pairs.size() == 0) begin
          $display("%0t: unexpected beat %p", $time, got);
          errors++;
        end else begin
          exp_r = expected_pairs.pop_front();
          if (got !== exp_r) begin
            $display("%0t: expected %p actual %p", $time, exp_r, got);
            errors++;
          end
        end
        out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic add_req(input logic [1:0] op, input logic [31:0] key,
                         input logic present, input logic [ROW_W-1:0] row);
    join_req_t r;
    r = {op, key, present, row};
    pending_reqs = {pending_reqs, r};
  endtask

  // Wait until every beat is taken and every result has arrived.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_ch.valid) @(posedge clk);
    @(posedge clk);
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  task automatic write_build_left(input logic val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= {31'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    shadow_build_left = val;
  endtask

  // Random phase: builds and probes, with some unused ops and clears, over a small key pool so probes hit.
  task automatic random_phase(input int n, input int pool);
    logic [31:0] keys[8];
    foreach (keys[i]) keys[i] = $urandom();
    keys[0] = 32'h8000_0000;
    keys[1] = 32'h7fff_ffff;
    for (int i = 0; i < n; i++) begin
      int pick;
      logic [1:0] op;
      pick = $urandom_range(0, 99);
      op = pick < 50 ? OP_BUILD : pick < 93 ? OP_PROBE : pick < 96 ? OP_SPARE : OP_CLEAR;
      add_req(op, ($urandom_range(0, 9) == 0) ? $urandom() : keys[$urandom_range(0, pool - 1)],
              $urandom_range(0, 9) != 0, ROW_W'($urandom()));
    end
  endtask

  initial begin
    logic [31:0] same_key;
    errors = 0; pairs_seen = 0; ovf_seen = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    shadow_fill = 0;
    shadow_build_left = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (1100) @(posedge clk);

    // Directed: extreme keys, absent keys, no match, unused op, clear.
    add_req(OP_BUILD, 32'h8000_0000, 1'b1, 20'hfffff);
    add_req(OP_BUILD, 32'h7fff_ffff, 1'b1, 20'h00000);
    add_req(OP_BUILD, 32'h8000_0000, 1'b1, 20'h12345);
    add_req(OP_BUILD, 32'h0000_0000, 1'b0, 20'h55555);
    add_req(OP_PROBE, 32'h8000_0000, 1'b1, 20'h00001);
    add_req(OP_PROBE, 32'h7fff_ffff, 1'b1, 20'hfffff);
    add_req(OP_PROBE, 32'h0000_0000, 1'b1, 20'haaaaa);
    add_req(OP_PROBE, 32'h8000_0000, 1'b0, 20'h00002);
    add_req(OP_SPARE, 32'h7fff_ffff, 1'b1, 20'h00003);
    add_req(OP_CLEAR, 32'hffff_ffff, 1'b1, 20'hfffff);
    add_req(OP_PROBE, 32'h8000_0000, 1'b1, 20'h00004);
    drain();

    // Per-key limit: one key past its match limit, then a full probe.
    write_build_left(1'b0);
    same_key = $urandom();
    for (int i = 0; i < MAX_MATCHES + 2; i++) add_req(OP_BUILD, same_key, 1'b1, ROW_W'(i));
    add_req(OP_PROBE, same_key, 1'b1, 20'h0beef);
    drain();

    random_phase(80, 8);
    drain();
    write_build_left(1'b1);
    random_phase(70, 3);
    drain();

    // Empty the table before switching the pair order again.
    add_req(OP_CLEAR, '0, 1'b1, '0);
    drain();
    write_build_left(1'b0);
    random_phase(80, 4);
    drain();

    $display("Covered both pair orders, clears, absent keys, unused ops and per-key overflow.");
    $display("Result beats: %0d pairs, %0d overflows, %0d errors.", pairs_seen, ovf_seen, errors);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
